// ----- rtl/teq_pkg.sv -----
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants for the timed event queue: request and
// response packets, operation and result codes, compare unit modes.
// ----------------------------------------------------------------------------
package teq_pkg;

   // default sizing
   localparam int DEPTH_DEF   = 16;
   localparam int ID_BITS_DEF = 16;

   // fixed field widths
   localparam int TIME_W = 32;
   localparam int FID_W  = 16;
   localparam int RMV_W  = 5;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_ADD_LIST = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_ADVANCE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ACK   = 2'd0,
      KIND_FIRED = 2'd1,
      KIND_NONE  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_PAST = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   // compare unit modes
   typedef enum logic [2:0] {
      CMP_LT  = 3'd0,   // a <  b
      CMP_LE  = 3'd1,   // a <= b
      CMP_EQ  = 3'd2,   // a == b
      CMP_GT  = 3'd3,   // a >  b
      CMP_WIN = 3'd4    // b < a <= c
   } cmp_mode_type;

   typedef struct packed {
      op_type              op;
      logic [TIME_W-1:0]   event_time;
      logic [FID_W-1:0]    event_id;
      logic [TIME_W-1:0]   time_value;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      status_type          status;
      logic [RMV_W-1:0]    removed_count;
      logic [FID_W-1:0]    fired_id;
      logic [TIME_W-1:0]   fired_time;
      logic                last;
   } rsp_type;

   // one response handed from the sequencer to the output register
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } rsp_push_type;

endpackage

// ----- rtl/teq_cmp.sv -----
// ----------------------------------------------------------------------------
// teq_cmp
// Shared time compare unit. Every time comparison of the sequencer (past
// check, purge match, fire window, insert position) goes through this one unit.
// ----------------------------------------------------------------------------
module teq_cmp (
   input  teq_pkg::cmp_mode_type        mode,
   input  logic [teq_pkg::TIME_W-1:0]   a,
   input  logic [teq_pkg::TIME_W-1:0]   b,
   input  logic [teq_pkg::TIME_W-1:0]   c,
   output logic                         hit
);

   logic a_lt_b;
   logic a_eq_b;
   logic a_le_c;

   assign a_lt_b = (a < b);
   assign a_eq_b = (a == b);
   assign a_le_c = (a <= c);

   // mode select
   always_comb begin
      case (mode)
         teq_pkg::CMP_LT:  hit = a_lt_b;
         teq_pkg::CMP_LE:  hit = a_lt_b | a_eq_b;
         teq_pkg::CMP_EQ:  hit = a_eq_b;
         teq_pkg::CMP_GT:  hit = ~(a_lt_b | a_eq_b);
         teq_pkg::CMP_WIN: hit = ~(a_lt_b | a_eq_b) & a_le_c;
         default:          hit = 1'b0;
      endcase
   end

endmodule

// ----- rtl/teq_mem.sv -----
// ----------------------------------------------------------------------------
// teq_mem
// Event table storage: due time and id per entry, one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module teq_mem #(
   parameter int DEPTH = teq_pkg::DEPTH_DEF,
   parameter int ID_W  = teq_pkg::ID_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [teq_pkg::TIME_W-1:0]    rd_time,
   output logic [ID_W-1:0]               rd_id,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [teq_pkg::TIME_W-1:0]    wr_time,
   input  logic [ID_W-1:0]               wr_id
);

   logic [teq_pkg::TIME_W-1:0] time_mem [DEPTH];
   logic [ID_W-1:0]            id_mem   [DEPTH];
   logic [teq_pkg::TIME_W-1:0] rd_time_ff;
   logic [ID_W-1:0]            rd_id_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= wr_time;
         id_mem[wr_addr]   <= wr_id;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_time_ff <= time_mem[rd_addr];
         rd_id_ff   <= id_mem[rd_addr];
      end
   end

   assign rd_time = rd_time_ff;
   assign rd_id   = rd_id_ff;

endmodule

// ----- rtl/teq_seq.sv -----
// ----------------------------------------------------------------------------
// teq_seq
// Operation sequencer: walks the event table one entry at a time through
// the shared compare unit, compacting on purge/fire and shifting on insert.
// ----------------------------------------------------------------------------
module teq_seq #(
   parameter int DEPTH   = teq_pkg::DEPTH_DEF,
   parameter int ID_BITS = teq_pkg::ID_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  teq_pkg::req_type       req_data,
   input  logic                   slot_free,
   output teq_pkg::rsp_push_type  push
);

   localparam int IdW  = (ID_BITS < teq_pkg::FID_W) ? ID_BITS : teq_pkg::FID_W;
   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam int TW   = teq_pkg::TIME_W;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DISPATCH = 8'b0000_0010,
      ST_SCAN_RD  = 8'b0000_0100,
      ST_SCAN_EV  = 8'b0000_1000,
      ST_SCAN_END = 8'b0001_0000,
      ST_INS_RD   = 8'b0010_0000,
      ST_INS_EV   = 8'b0100_0000,
      ST_ACK      = 8'b1000_0000
   } state_type;

   state_type                state_ff, state_in;
   teq_pkg::op_type          op_ff, op_in;
   logic [TW-1:0]            et_ff, et_in;
   logic [IdW-1:0]           id_ff, id_in;
   logic [TW-1:0]            tv_ff, tv_in;
   logic [TW-1:0]            hi_ff, hi_in;
   logic [TW-1:0]            now_ff, now_in;
   logic [CntW-1:0]          count_ff, count_in;
   logic [CntW-1:0]          i_ff, i_in;
   logic [CntW-1:0]          w_ff, w_in;
   logic [CntW-1:0]          pos_ff, pos_in;
   logic [CntW-1:0]          pos_dec;
   logic                     held_valid_ff, held_valid_in;
   logic [TW-1:0]            held_time_ff, held_time_in;
   logic [IdW-1:0]           held_id_ff, held_id_in;
   teq_pkg::status_type      status_ff, status_in;
   logic [teq_pkg::RMV_W-1:0] removed_ff, removed_in;

   // table port
   logic                     rd_en;
   logic [IdxW-1:0]          rd_addr;
   logic [TW-1:0]            rd_time;
   logic [IdW-1:0]           rd_id;
   logic                     wr_en;
   logic [IdxW-1:0]          wr_addr;
   logic [TW-1:0]            wr_time;
   logic [IdW-1:0]           wr_id;

   // compare unit port
   teq_pkg::cmp_mode_type    cmp_mode;
   logic [TW-1:0]            cmp_a;
   logic [TW-1:0]            cmp_b;
   logic [TW-1:0]            cmp_c;
   logic                     cmp_hit;

   teq_mem #(
      .DEPTH (DEPTH),
      .ID_W  (IdW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_time (rd_time),
      .rd_id   (rd_id),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_time (wr_time),
      .wr_id   (wr_id)
   );

   teq_cmp u_cmp (
      .mode (cmp_mode),
      .a    (cmp_a),
      .b    (cmp_b),
      .c    (cmp_c),
      .hit  (cmp_hit)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign pos_dec   = pos_ff - CntW'(1);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      et_in         = et_ff;
      id_in         = id_ff;
      tv_in         = tv_ff;
      hi_in         = hi_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      w_in          = w_ff;
      pos_in        = pos_ff;
      held_valid_in = held_valid_ff;
      held_time_in  = held_time_ff;
      held_id_in    = held_id_ff;
      status_in     = status_ff;
      removed_in    = removed_ff;

      rd_en    = 1'b0;
      rd_addr  = i_ff[IdxW-1:0];
      wr_en    = 1'b0;
      wr_addr  = w_ff[IdxW-1:0];
      wr_time  = rd_time;
      wr_id    = rd_id;
      cmp_mode = teq_pkg::CMP_LT;
      cmp_a    = et_ff;
      cmp_b    = now_ff;
      cmp_c    = hi_ff;
      push     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.op;
               et_in    = req_data.event_time;
               id_in    = req_data.event_id[IdW-1:0];
               tv_in    = req_data.time_value;
               state_in = ST_DISPATCH;
            end
         end

         // past/full check for a plain add, otherwise start a table scan
         ST_DISPATCH: begin
            held_valid_in = 1'b0;
            hi_in         = now_ff + tv_ff;
            i_in          = '0;
            w_in          = '0;
            status_in     = teq_pkg::STAT_OK;
            removed_in    = '0;
            if (op_ff == teq_pkg::OP_ADD) begin
               if (cmp_hit) begin
                  status_in = teq_pkg::STAT_PAST;
                  state_in  = ST_ACK;
               end else if (count_ff == CntW'(DEPTH)) begin
                  status_in = teq_pkg::STAT_FULL;
                  state_in  = ST_ACK;
               end else begin
                  pos_in   = count_ff;
                  state_in = ST_INS_RD;
               end
            end else begin
               state_in = ST_SCAN_RD;
            end
         end

         ST_SCAN_RD: begin
            if (i_ff == count_ff) begin
               state_in = ST_SCAN_END;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_SCAN_EV;
            end
         end

         // keep: compact down to w; drop: skip, firing it on an advance
         ST_SCAN_EV: begin
            cmp_a = rd_time;
            case (op_ff)
               teq_pkg::OP_ADD_LIST: cmp_mode = teq_pkg::CMP_LE;
               teq_pkg::OP_REMOVE: begin
                  cmp_mode = teq_pkg::CMP_EQ;
                  cmp_b    = tv_ff;
               end
               default:              cmp_mode = teq_pkg::CMP_WIN;
            endcase
            if (!cmp_hit) begin
               wr_en    = 1'b1;
               w_in     = w_ff + CntW'(1);
               i_in     = i_ff + CntW'(1);
               state_in = ST_SCAN_RD;
            end else if (op_ff == teq_pkg::OP_ADVANCE) begin
               // previous fired entry goes out once this one is known
               if (!held_valid_ff || slot_free) begin
                  push.valid              = held_valid_ff;
                  push.data.kind          = teq_pkg::KIND_FIRED;
                  push.data.status        = teq_pkg::STAT_OK;
                  push.data.removed_count = '0;
                  push.data.fired_id      = teq_pkg::FID_W'(held_id_ff);
                  push.data.fired_time    = held_time_ff;
                  push.data.last          = 1'b0;
                  held_valid_in = 1'b1;
                  held_time_in  = rd_time;
                  held_id_in    = rd_id;
                  i_in          = i_ff + CntW'(1);
                  state_in      = ST_SCAN_RD;
               end
            end else begin
               i_in     = i_ff + CntW'(1);
               state_in = ST_SCAN_RD;
            end
         end

         ST_SCAN_END: begin
            count_in = w_ff;
            case (op_ff)
               teq_pkg::OP_ADD_LIST: begin
                  cmp_mode = teq_pkg::CMP_LE;
                  if (cmp_hit) begin
                     status_in = teq_pkg::STAT_PAST;
                     state_in  = ST_ACK;
                  end else if (w_ff == CntW'(DEPTH)) begin
                     status_in = teq_pkg::STAT_FULL;
                     state_in  = ST_ACK;
                  end else begin
                     pos_in   = w_ff;
                     state_in = ST_INS_RD;
                  end
               end
               teq_pkg::OP_REMOVE: begin
                  removed_in = teq_pkg::RMV_W'(count_ff - w_ff);
                  state_in   = ST_ACK;
               end
               teq_pkg::OP_ADVANCE: begin
                  now_in   = hi_ff;
                  state_in = ST_ACK;
               end
               default: state_in = ST_ACK;
            endcase
         end

         // walk down from the tail looking for the insert slot
         ST_INS_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_time  = et_ff;
               wr_id    = id_ff;
               count_in = count_ff + CntW'(1);
               state_in = ST_ACK;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = pos_dec[IdxW-1:0];
               state_in = ST_INS_EV;
            end
         end

         ST_INS_EV: begin
            cmp_mode = teq_pkg::CMP_GT;
            cmp_a    = rd_time;
            cmp_b    = et_ff;
            wr_en    = 1'b1;
            wr_addr  = pos_ff[IdxW-1:0];
            if (cmp_hit) begin
               pos_in   = pos_dec;
               state_in = ST_INS_RD;
            end else begin
               wr_time  = et_ff;
               wr_id    = id_ff;
               count_in = count_ff + CntW'(1);
               state_in = ST_ACK;
            end
         end

         // final response of the request
         ST_ACK: begin
            if (slot_free) begin
               push.valid              = 1'b1;
               push.data.kind          = teq_pkg::KIND_ACK;
               push.data.status        = status_ff;
               push.data.removed_count = removed_ff;
               push.data.fired_id      = '0;
               push.data.fired_time    = '0;
               push.data.last          = 1'b1;
               if (op_ff == teq_pkg::OP_ADVANCE) begin
                  push.data.status = teq_pkg::STAT_OK;
                  if (held_valid_ff) begin
                     push.data.kind       = teq_pkg::KIND_FIRED;
                     push.data.fired_id   = teq_pkg::FID_W'(held_id_ff);
                     push.data.fired_time = held_time_ff;
                  end else begin
                     push.data.kind = teq_pkg::KIND_NONE;
                  end
               end
               held_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         count_ff      <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      et_ff        <= et_in;
      id_ff        <= id_in;
      tv_ff        <= tv_in;
      hi_ff        <= hi_in;
      i_ff         <= i_in;
      w_ff         <= w_in;
      pos_ff       <= pos_in;
      held_time_ff <= held_time_in;
      held_id_ff   <= held_id_in;
      status_ff    <= status_in;
      removed_ff   <= removed_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("entry count above table depth");

   a_push_slot: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> slot_free)
      else $error("response pushed into a busy output register");

   a_scan_ptrs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_EV) |-> ((w_ff <= i_ff) && (i_ff < count_ff)))
      else $error("scan pointers out of order");

   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_RD) |-> (count_ff < CntW'(DEPTH)))
      else $error("insert started on a full table");

   a_ack_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACK && slot_free) |=> (state_ff == ST_IDLE))
      else $error("final response did not end the request");
`endif

endmodule

// ----- rtl/timed_event_queue.sv -----
// ----------------------------------------------------------------------------
// timed_event_queue
// Time-ordered table of pending events with a current time. Requests add,
// purge-and-add, remove by time, or advance time and fire due events.
//
//   channel | ports                          | moves
//   --------+--------------------------------+----------------------------
//   req     | req_valid, req_stall, req_data | one operation request
//   rsp     | rsp_valid, rsp_stall, rsp_data | ack, fired event, or none
//
// One request at a time; req_stall is high from acceptance until the final
// response is in the output register. Every request passes through dispatch
// and ends in the final response state. A scan or an insert visits one table
// entry at a time through a read state and an evaluate state on the single
// table read port, and the block returns to idle before the next request is
// taken.
// Reset clears the current time and entry count; table contents need none.
// A stalled response port holds the sequencer at the next fired event.
// ----------------------------------------------------------------------------
module timed_event_queue #(
   parameter int DEPTH   = teq_pkg::DEPTH_DEF,
   parameter int ID_BITS = teq_pkg::ID_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  teq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output teq_pkg::rsp_type  rsp_data
);

   teq_pkg::rsp_push_type push;
   logic                  slot_free;
   logic                  rsp_valid_ff;
   teq_pkg::rsp_type      rsp_data_ff;

   teq_seq #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .slot_free (slot_free),
      .push      (push)
   );

   // output register
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         rsp_data_ff <= push.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for timed_event_queue. A short table of requests hits
// the corner cases first: empty table, equal due times, past and full drops,
// the wrapped window and a full-table remove. After that come random
// requests built around the current time. A local model of the event table
// predicts the untyped responses; every response is checked field by field.
// ----------------------------------------------------------------------------
module tb;

   localparam int DEPTH        = teq_pkg::DEPTH_DEF;
   localparam int ID_BITS      = teq_pkg::ID_BITS_DEF;
   localparam int TIME_W       = teq_pkg::TIME_W;
   localparam int FID_W        = teq_pkg::FID_W;
   localparam int RMV_W        = teq_pkg::RMV_W;
   localparam int RAND_ITEMS   = 330;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 100;
   localparam int LIMIT_CYCLES = 400000;
   localparam logic [FID_W-1:0] ID_MASK = FID_W'((64'd1 << ID_BITS) - 1);

   typedef struct {
      teq_pkg::req_type req;
      bit               typed;
      teq_pkg::rsp_type want;
   } dir_row_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   teq_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   teq_pkg::rsp_type rsp_data;

   // model of the event table
   logic [TIME_W-1:0] tq_due [DEPTH];
   logic [FID_W-1:0]  tq_id  [DEPTH];
   int                tq_count = 0;
   logic [TIME_W-1:0] tq_now   = '0;

   teq_pkg::rsp_type outcome_q[$];     // responses of the latest request
   teq_pkg::rsp_type awaited_rsp[$];   // responses still owed by the block
   dir_row_type      dir_rows[$];

   int mismatches  = 0;
   int cycle_count = 0;
   int hold_asked  = 0;
   int hold_served = 0;
   int burst_left  = 0;

   timed_event_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // queue tails
   function automatic void add_outcome(teq_pkg::rsp_type x);
      outcome_q.insert(outcome_q.size(), x);
   endfunction

   function automatic void add_awaited(teq_pkg::rsp_type x);
      awaited_rsp.insert(awaited_rsp.size(), x);
   endfunction

   // place after every entry due at or before t
   function automatic teq_pkg::status_type table_insert(logic [TIME_W-1:0] t,
                                                       logic [FID_W-1:0] id);
      int pos;
      if (tq_count >= DEPTH) return teq_pkg::STAT_FULL;
      pos = tq_count;
      while (pos > 0 && tq_due[pos-1] > t) begin
         tq_due[pos] = tq_due[pos-1];
         tq_id[pos]  = tq_id[pos-1];
         pos--;
      end
      tq_due[pos] = t;
      tq_id[pos]  = id;
      tq_count++;
      return teq_pkg::STAT_OK;
   endfunction

   // drop entries equal to t, or at or below t
   function automatic logic [RMV_W-1:0] table_purge(logic [TIME_W-1:0] t, bit at_or_below);
      int  w;
      int  n;
      bit  drop;
      w = 0;
      n = tq_count;
      for (int i = 0; i < n; i++) begin
         drop = at_or_below ? (tq_due[i] <= t) : (tq_due[i] == t);
         if (!drop) begin
            tq_due[w] = tq_due[i];
            tq_id[w]  = tq_id[i];
            w++;
         end
      end
      tq_count = w;
      return RMV_W'(n - w);
   endfunction

   // apply one request to the model, responses land in outcome_q
   function automatic void apply_request(teq_pkg::req_type r);
      logic [TIME_W-1:0] hi;
      logic [TIME_W-1:0] t;
      logic [FID_W-1:0]  id;
      teq_pkg::rsp_type  x;
      int                w;
      int                n;
      outcome_q.delete();
      id = r.event_id & ID_MASK;
      x = '0;
      x.last = 1'b1;
      case (r.op)
         teq_pkg::OP_ADD: begin
            x.status = (r.event_time < tq_now) ? teq_pkg::STAT_PAST
                                               : table_insert(r.event_time, id);
            add_outcome(x);
         end
         teq_pkg::OP_ADD_LIST: begin
            void'(table_purge(tq_now, 1'b1));
            x.status = (r.event_time <= tq_now) ? teq_pkg::STAT_PAST
                                                : table_insert(r.event_time, id);
            add_outcome(x);
         end
         teq_pkg::OP_REMOVE: begin
            x.removed_count = table_purge(r.time_value, 1'b0);
            add_outcome(x);
         end
         default: begin
            // fire (now, now+delta] in table order; a wrapped sum gives nothing
            hi = tq_now + r.time_value;
            w = 0;
            n = tq_count;
            for (int i = 0; i < n; i++) begin
               t = tq_due[i];
               if (tq_now < t && t <= hi) begin
                  x = '0;
                  x.kind       = teq_pkg::KIND_FIRED;
                  x.fired_id   = tq_id[i];
                  x.fired_time = t;
                  add_outcome(x);
               end else begin
                  tq_due[w] = t;
                  tq_id[w]  = tq_id[i];
                  w++;
               end
            end
            tq_count = w;
            tq_now = hi;
            if (outcome_q.size() == 0) begin
               x = '0;
               x.kind = teq_pkg::KIND_NONE;
               x.last = 1'b1;
               add_outcome(x);
            end else begin
               x = outcome_q.pop_back();
               x.last = 1'b1;
               add_outcome(x);
            end
         end
      endcase
   endfunction

   function automatic void add_row(teq_pkg::op_type op, logic [TIME_W-1:0] et,
                                   logic [FID_W-1:0] id, logic [TIME_W-1:0] tv,
                                   bit typed, teq_pkg::kind_type k,
                                   teq_pkg::status_type s, logic [RMV_W-1:0] rc);
      dir_row_type row;
      row.req.op         = op;
      row.req.event_time = et;
      row.req.event_id   = id;
      row.req.time_value = tv;
      row.typed          = typed;
      row.want           = '0;
      row.want.kind      = k;
      row.want.status    = s;
      row.want.removed_count = rc;
      row.want.last      = 1'b1;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   // random request shaped around the model's current time and contents
   function automatic teq_pkg::req_type make_item(int phase);
      teq_pkg::req_type r;
      int      pick;
      int      c;
      int      lim_add;
      int      lim_list;
      int      lim_rem;
      case (phase)
         0:       begin lim_add = 60; lim_list = 70; lim_rem = 80; end
         1:       begin lim_add = 35; lim_list = 50; lim_rem = 70; end
         default: begin lim_add = 15; lim_list = 25; lim_rem = 55; end
      endcase
      pick = $urandom_range(0, 99);
      c    = $urandom_range(0, 9);
      r.event_id   = FID_W'($urandom);
      r.event_time = $urandom;
      r.time_value = $urandom;
      if (pick < lim_add)       r.op = teq_pkg::OP_ADD;
      else if (pick < lim_list) r.op = teq_pkg::OP_ADD_LIST;
      else if (pick < lim_rem)  r.op = teq_pkg::OP_REMOVE;
      else                      r.op = teq_pkg::OP_ADVANCE;
      case (r.op)
         teq_pkg::OP_ADD, teq_pkg::OP_ADD_LIST: begin
            if (c == 1 && tq_count > 0) r.event_time = tq_due[$urandom_range(0, tq_count-1)];
            else if (c == 2)            r.event_time = tq_now;
            else if (c == 3)            r.event_time = tq_now - $urandom_range(1, 20);
            else if (c != 0)            r.event_time = tq_now + $urandom_range(1, 60);
         end
         teq_pkg::OP_REMOVE: begin
            if (c < 7 && tq_count > 0) r.time_value = tq_due[$urandom_range(0, tq_count-1)];
            else if (c == 7)           r.time_value = tq_now;
            else if (c == 8)           r.time_value = tq_now + $urandom_range(0, 60);
         end
         default: begin
            if (c == 1)      r.time_value = '0;
            else if (c == 2) r.time_value = 32'hFFFF_FFFF - $urandom_range(0, 30);
            else if (c == 3) r.time_value = $urandom_range(40, 120);
            else if (c != 0) r.time_value = $urandom_range(1, 30);
         end
      endcase
      return r;
   endfunction

   // offer one request, record what it owes once accepted
   task automatic offer(teq_pkg::req_type r, bit typed, teq_pkg::rsp_type want);
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(posedge clock);
      end while (req_stall);
      apply_request(r);
      if (typed) add_awaited(want);
      else foreach (outcome_q[j]) add_awaited(outcome_q[j]);
   endtask

   // sender bursts with random gaps, sometimes long stretches without gaps
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stimulus
   initial begin : stimulus
      int               phase;
      teq_pkg::req_type r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table
      add_row(teq_pkg::OP_ADVANCE, 32'h0, 16'h0, 32'h0, 1'b1,
              teq_pkg::KIND_NONE, teq_pkg::STAT_OK, '0);
      add_row(teq_pkg::OP_REMOVE, 32'h0, 16'h0, 32'h0, 1'b1,
              teq_pkg::KIND_ACK, teq_pkg::STAT_OK, '0);
      add_row(teq_pkg::OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 1'b1,
              teq_pkg::KIND_ACK, teq_pkg::STAT_OK, '0);
      add_row(teq_pkg::OP_ADD, 32'd5, 16'hA5A5, 32'h0, 1'b0,
              teq_pkg::KIND_ACK, teq_pkg::STAT_OK, '0);
      // equal due time keeps insertion order
      add_row(teq_pkg::OP_ADD, 32'd5, 16'h5A5A, 32'hFFFF_FFFF, 1'b0,
              teq_pkg::KIND_ACK, teq_pkg::STAT_OK, '0);
      // due at now: stays behind, never fires
      add_row(teq_pkg::OP_ADD, 32'd0, 16'h0, 32'h0, 1'b1,
              teq_pkg::KIND_ACK, teq_pkg::STAT_OK, '0);
      add_row(teq_pkg::OP_ADVANCE, 32'h0, 16'h0, 32'd5, 1'b0,
              teq_pkg::KIND_ACK, teq_pkg::STAT_OK, '0);
      add_row(teq_pkg::OP_ADD, 32'd4, 16'h1, 32'h0, 1'b1,
              teq_pkg::KIND_ACK, teq_pkg::STAT_PAST, '0);
      // list add purges the stale entry, then drops an event at now
      add_row(teq_pkg::OP_ADD_LIST, 32'd5, 16'h2, 32'h0, 1'b1,
              teq_pkg::KIND_ACK, teq_pkg::STAT_PAST, '0);
      // wrapped window fires nothing
      add_row(teq_pkg::OP_ADVANCE, 32'h0, 16'h0, 32'hFFFF_FFFF, 1'b1,
              teq_pkg::KIND_NONE, teq_pkg::STAT_OK, '0);
      add_row(teq_pkg::OP_ADVANCE, 32'h0, 16'h0, 32'hFFFF_FFFB, 1'b0,
              teq_pkg::KIND_ACK, teq_pkg::STAT_OK, '0);
      add_row(teq_pkg::OP_ADVANCE, 32'h0, 16'h0, 32'd1, 1'b1,
              teq_pkg::KIND_NONE, teq_pkg::STAT_OK, '0);
      // fill the table at one due time
      for (int i = 0; i < DEPTH; i++)
         add_row(teq_pkg::OP_ADD, 32'h8000_0000, FID_W'(i * 16'h1111), 32'h0, 1'b1,
                 teq_pkg::KIND_ACK, teq_pkg::STAT_OK, '0);
      add_row(teq_pkg::OP_ADD, 32'd1, 16'h1234, 32'h0, 1'b1,
              teq_pkg::KIND_ACK, teq_pkg::STAT_FULL, '0);
      add_row(teq_pkg::OP_ADD_LIST, 32'h8000_0000, 16'h4321, 32'h0, 1'b1,
              teq_pkg::KIND_ACK, teq_pkg::STAT_FULL, '0);
      add_row(teq_pkg::OP_REMOVE, 32'h0, 16'h0, 32'h8000_0000, 1'b1,
              teq_pkg::KIND_ACK, teq_pkg::STAT_OK, RMV_W'(DEPTH));

      foreach (dir_rows[k]) begin
         offer(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
         pace();
      end

      // random requests; phases lean toward fill, mixed, then drain
      for (int i = 0; i < RAND_ITEMS; i++) begin
         phase = (i / 40) % 3;
         if (i == 120) hold_asked++;
         r = make_item(phase);
         offer(r, 1'b0, '0);
         if (i == 250) begin
            // pause until the block has answered everything
            req_valid <= 1'b0;
            @(posedge clock);
            while (awaited_rsp.size() != 0) @(posedge clock);
         end else if (i != RAND_ITEMS - 1) begin
            pace();
         end
      end
      req_valid <= 1'b0;

      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   // receiver stall patterns, plus one long hold-off on request
   initial begin : rsp_side
      int mode;
      int span;
      int per;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(30, 150);
         per  = $urandom_range(2, 6);
         for (int k = 0; k < span; k++) begin
            @(posedge clock);
            if (hold_asked != hold_served) begin
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               rsp_stall <= 1'b0;
               hold_served++;
            end else begin
               case (mode)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 2) == 0);
                  2:       rsp_stall <= (k % per == 0);
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
            end
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // response checker
   always @(posedge clock) begin : rsp_check
      teq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: response with none expected, got %h", $time, rsp_data);
            mismatches++;
         end else begin
            want = awaited_rsp.pop_front();
            check_field("kind",          want.kind,          rsp_data.kind);
            check_field("status",        want.status,        rsp_data.status);
            check_field("removed_count", want.removed_count, rsp_data.removed_count);
            check_field("fired_id",      want.fired_id,      rsp_data.fired_id);
            check_field("fired_time",    want.fired_time,    rsp_data.fired_time);
            check_field("last",          want.last,          rsp_data.last);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule
